/* sv/tcmf_pkg.sv */
// Package for the touch coordinate map filter: field widths, register
// indexes, calibration reset values, sequencer states and divider status.
// No dependencies.
`default_nettype none

package tcmf_pkg;

	localparam int RAW_W      = 12;  // raw converter reading and edge registers
	localparam int PIX_W      = 9;   // pixel fields on the result beat
	localparam int IN_DATA_W  = 24;  // raw_x, raw_y
	localparam int OUT_DATA_W = 24;  // screen_x, screen_y, zero padding
	localparam int OUT_USER_W = 2;   // is_pressed, press_start
	localparam int CFG_IDX_W  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEFT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_RIGHT  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOP    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_BOTTOM = 4'd3;

	localparam logic [RAW_W-1:0] EDGE_LEFT_RST   = 12'd3900;
	localparam logic [RAW_W-1:0] EDGE_RIGHT_RST  = 12'd100;
	localparam logic [RAW_W-1:0] EDGE_TOP_RST    = 12'd120;
	localparam logic [RAW_W-1:0] EDGE_BOTTOM_RST = 12'd3900;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

/* sv/tcmf_div.sv */
// Shared restoring divider for the coordinate map: one quotient bit a cycle.
// Depends on tcmf_pkg (div_stat_t). The caller guarantees num < den << QW.
`default_nettype none

module tcmf_div import tcmf_pkg::*; #(
	parameter int DW = 12,
	parameter int QW = 9
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DW+QW-1:0] num,
	input  wire logic [DW-1:0]    den,
	output logic      [QW-1:0]    quo,
	output div_stat_t             stat
);

	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic          fits;
	logic [DW:0]   diff;
	logic [QW:0]   quo_shift;

	assign trial     = {rem_q, quo_q[QW-1]};
	assign fits      = trial >= {1'b0, den_q};
	assign diff      = trial - {1'b0, den_q};
	assign quo_shift = {quo_q, fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// upper numerator bits seed the remainder, lower bits shift through the quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DW+QW-1:QW];
			quo_q <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= quo_shift[QW-1:0];
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !start |=> !done_q)
		else $error("divider done held longer than one cycle");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

/* sv/touch_coordinate_map_filter_core.sv */
// Touch coordinate map filter: maps raw touch readings to screen pixels and
// smooths them while pressed. Depends on tcmf_pkg and tcmf_div.
//
// Use:
//   s_axis carries one touch sample a beat: tdata {raw_y, raw_x}, tuser touch_down.
//   m_axis returns one result a beat: tdata {pad, screen_y, screen_x},
//   tuser {press_start, is_pressed}.
//   cfg writes one calibration edge a beat (index 0..3: left, right, top,
//   bottom); cfg_ready is always high. Write only while no sample is in flight.
// Sequence:
//   Each accepted sample is classified axis by axis, x then y; an axis inside
//   its edges gets a multiply and a Q-bit divide, Q = clog2(max(SCREEN_WIDTH,
//   SCREEN_HEIGHT)), and a clamped axis skips its multiply and divide.
//   One multiplier and one bit-serial divider serve both axes in turn.
//   s_axis_tready is high only in idle: one sample is processed at a time.
// Reset:
//   Edges return to 3900/100/120/3900, the filter is unloaded, no press seen.
// Stall:
//   A finished result waits in the output register; the next sample is
//   accepted meanwhile and its result waits until that register is free.
`default_nettype none

module touch_coordinate_map_filter_core import tcmf_pkg::*; #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 272
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] raw_x, [23:12] raw_y
	input  wire logic                  s_axis_tuser,   // [0] touch_down
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,   // [8:0] screen_x, [17:9] screen_y
	output logic      [OUT_USER_W-1:0] m_axis_tuser,   // [0] is_pressed, [1] press_start
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [RAW_W-1:0]      cfg_data
);

	localparam int XW = $clog2(SCREEN_WIDTH);
	localparam int YW = $clog2(SCREEN_HEIGHT);
	localparam int QW = (XW > YW) ? XW : YW;
	localparam int NW = RAW_W + QW;
	localparam logic [QW-1:0] LAST_X = QW'(SCREEN_WIDTH - 1);
	localparam logic [QW-1:0] LAST_Y = QW'(SCREEN_HEIGHT - 1);
	localparam logic [XW-1:0] SX_RST = XW'(SCREEN_WIDTH / 2);
	localparam logic [YW-1:0] SY_RST = YW'(SCREEN_HEIGHT / 2);

	seq_state_t state_q, state_d;

	logic [RAW_W-1:0] edge_left_q, edge_right_q, edge_top_q, edge_bottom_q;
	logic             touch_q;
	logic [RAW_W-1:0] raw_x_q, raw_y_q;
	logic             axis_q;
	logic [RAW_W-1:0] delta_q, run_q;
	logic [QW-1:0]    map_x_q, map_y_q;
	logic [XW-1:0]    smooth_x_q;
	logic [YW-1:0]    smooth_y_q;
	logic             loaded_q;
	logic             prev_pressed_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_x_q, out_y_q;
	logic             out_pressed_q, out_start_q;

	logic             in_take;
	logic             div_start;
	logic             out_free;
	div_stat_t        div_stat;
	logic [QW-1:0]    div_quo;
	logic [NW-1:0]    product;

	logic [RAW_W-1:0] raw_sel, e0, e1;
	logic [QW-1:0]    last_sel;
	logic             map_fixed;
	logic [QW-1:0]    map_val;
	logic [RAW_W-1:0] cls_delta, cls_run;

	logic [QW-1:0]    filt_x, filt_y;
	logic [QW-1:0]    res_x, res_y;
	logic [PIX_W+QW-1:0] ext_x, ext_y;
	logic             press_start;

	// new = floor((3*old + target)/4), hold old when it moves by one or less
	function automatic logic [QW-1:0] smooth_step(logic [QW-1:0] old, logic [QW-1:0] tgt);
		logic [QW+1:0] sum;
		logic [QW-1:0] nv;
		logic [QW-1:0] moved;
		sum   = ({2'b00, old} << 1) + {2'b00, old} + {2'b00, tgt};
		nv    = sum[QW+1:2];
		moved = (nv > old) ? (nv - old) : (old - nv);
		return (moved <= QW'(1)) ? old : nv;
	endfunction

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_left_q   <= EDGE_LEFT_RST;
			edge_right_q  <= EDGE_RIGHT_RST;
			edge_top_q    <= EDGE_TOP_RST;
			edge_bottom_q <= EDGE_BOTTOM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_EDGE_LEFT:   edge_left_q   <= cfg_data;
				REG_EDGE_RIGHT:  edge_right_q  <= cfg_data;
				REG_EDGE_TOP:    edge_top_q    <= cfg_data;
				REG_EDGE_BOTTOM: edge_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- axis classification ----------------
	assign raw_sel  = axis_q ? raw_y_q : raw_x_q;
	assign e0       = axis_q ? edge_top_q : edge_left_q;
	assign e1       = axis_q ? edge_bottom_q : edge_right_q;
	assign last_sel = axis_q ? LAST_Y : LAST_X;

	always_comb begin
		map_fixed = 1'b1;
		map_val   = '0;
		cls_delta = '0;
		cls_run   = '0;
		if (e0 == e1) begin
			map_val = '0;
		end else if (e0 < e1) begin
			if (raw_sel <= e0) begin
				map_val = '0;
			end else if (raw_sel >= e1) begin
				map_val = last_sel;
			end else begin
				map_fixed = 1'b0;
				cls_delta = raw_sel - e0;
				cls_run   = e1 - e0;
			end
		end else begin
			if (raw_sel >= e0) begin
				map_val = '0;
			end else if (raw_sel <= e1) begin
				map_val = last_sel;
			end else begin
				map_fixed = 1'b0;
				cls_delta = e0 - raw_sel;
				cls_run   = e0 - e1;
			end
		end
	end

	assign product = NW'(delta_q) * NW'(last_sel);

	tcmf_div #(
		.DW (RAW_W),
		.QW (QW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (product),
		.den    (run_q),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	// ---------------- sequencer ----------------
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_MAP;
			ST_MAP: begin
				if (!map_fixed) state_d = ST_MUL;
				else if (axis_q) state_d = ST_DONE;
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (div_stat.done) state_d = axis_q ? ST_DONE : ST_MAP;
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_MUL:  div_start     = 1'b1;
			default: ;
		endcase
	end

	assign in_take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- filter and result ----------------
	assign filt_x = loaded_q ? smooth_step(QW'(smooth_x_q), map_x_q) : map_x_q;
	assign filt_y = loaded_q ? smooth_step(QW'(smooth_y_q), map_y_q) : map_y_q;
	assign res_x  = touch_q ? filt_x : map_x_q;
	assign res_y  = touch_q ? filt_y : map_y_q;
	assign ext_x  = (PIX_W + QW)'(res_x);
	assign ext_y  = (PIX_W + QW)'(res_y);
	assign press_start = touch_q && !prev_pressed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q         <= 1'b0;
			smooth_x_q     <= SX_RST;
			smooth_y_q     <= SY_RST;
			loaded_q       <= 1'b0;
			prev_pressed_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: axis_q <= 1'b0;
				ST_MAP:  if (map_fixed) axis_q <= 1'b1;
				ST_DIV:  if (div_stat.done) axis_q <= 1'b1;
				ST_DONE: begin
					if (out_free) begin
						prev_pressed_q <= touch_q;
						loaded_q       <= touch_q;
						if (touch_q) begin
							smooth_x_q <= filt_x[XW-1:0];
							smooth_y_q <= filt_y[YW-1:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			touch_q <= s_axis_tuser;
			raw_x_q <= s_axis_tdata[RAW_W-1:0];
			raw_y_q <= s_axis_tdata[2*RAW_W-1:RAW_W];
		end
		if (state_q == ST_MAP) begin
			delta_q <= cls_delta;
			run_q   <= cls_run;
			if (map_fixed) begin
				if (axis_q) map_y_q <= map_val;
				else        map_x_q <= map_val;
			end
		end
		if (state_q == ST_DIV && div_stat.done) begin
			if (axis_q) map_y_q <= div_quo;
			else        map_x_q <= div_quo;
		end
		if (state_q == ST_DONE && out_free) begin
			out_x_q       <= ext_x[PIX_W-1:0];
			out_y_q       <= ext_y[PIX_W-1:0];
			out_pressed_q <= touch_q;
			out_start_q   <= press_start;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - 2 * PIX_W)'(0), out_y_q, out_x_q};
	assign m_axis_tuser  = {out_start_q, out_pressed_q};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_stat.busy)
		else $error("sample accepted while divider busy");

	a_start_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_start_q || out_pressed_q))
		else $error("press start flagged without a press");

	a_loaded_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q |-> prev_pressed_q)
		else $error("filter loaded without a previous press");

	a_div_axis: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> run_q != '0)
		else $error("division started with zero run");

endmodule

`default_nettype wire
